// ----- hdl/alp_pkg.sv -----
`default_nettype none
package alp_pkg;

  localparam int MaxOrderDef = 32;

  // config register indexes
  localparam logic [1:0] REG_ORDER = 2'd0;
  localparam logic [1:0] REG_QSHIFT = 2'd1;
  localparam logic [1:0] REG_SBITS = 2'd2;

  // input item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [4:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] residual;
    logic               frame_start;
  } alp_in_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               warmup;
  } alp_out_t;

  // control from sequencer to tap pipeline
  typedef struct packed {
    logic       init;
    logic       p_valid;
    logic [4:0] j;
    logic [3:0] q;
  } alp_tap_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/alp_ram.sv -----
`default_nettype none
module alp_ram #(
  parameter int Width = 32,
  parameter int Aw = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [Aw-1:0]    waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [Aw-1:0]    raddr,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [2**Aw];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/alp_tap.sv -----
`default_nettype none
module alp_tap import alp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire alp_tap_ctl_t       ctl,
  input  wire logic [31:0]        res,
  input  wire logic [31:0]        d,
  input  wire logic [31:0]        hist_rd,
  input  wire logic [31:0]        coef_rd,
  output logic                    coef_we,
  output logic [31:0]             coef_wdata,
  output logic [31:0]             val,
  output logic                    busy
);

  logic [31:0] err_r, err_nxt;
  logic [31:0] t_r, c_r, prod_r, val_r;
  logic        mv_r, av_r;
  logic [31:0] t, x, xs, sh, wt;
  logic        err_ok, adapt, dec;

  // sign-sign adaptation of one tap
  always_comb begin
    t = hist_rd - d;
    x = 32'd0 - t;
    err_ok = (err_r != 32'd0) && (err_r[31] == res[31]);
    adapt = (res != 32'd0) && (t != 32'd0) && err_ok;
    dec = (x[31] == res[31]);
    xs = dec ? x : t;
    sh = 32'($signed(xs) >>> ctl.q);
    wt = sh * 32'({1'b0, ctl.j} + 6'd1);
    err_nxt = err_r - wt;
    coef_we = ctl.p_valid && adapt;
    coef_wdata = dec ? coef_rd - 32'd1 : coef_rd + 32'd1;
  end

  // tap stage, multiply stage, accumulate stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
      av_r <= 1'b0;
    end else begin
      mv_r <= ctl.p_valid;
      av_r <= mv_r;
    end
    if (ctl.init) begin
      err_r <= res;
      val_r <= 32'd0;
    end else begin
      if (ctl.p_valid && adapt) begin
        err_r <= err_nxt;
      end
      if (av_r) begin
        val_r <= val_r + prod_r;
      end
    end
    t_r <= t;
    c_r <= coef_rd;
    prod_r <= t_r * c_r;
  end

  assign val = val_r;
  assign busy = mv_r || av_r;

endmodule
`default_nettype wire

// ----- hdl/adaptive_lpc_predictor.sv -----
// Load items: accepted while idle, no result.
// Warm-up samples: result registered at the accepting edge.
// Predicted samples: one history/coefficient memory read per tap through a 3-stage tap pipeline.
// One item at a time. Synchronous active-low reset clears control and config
// to order 0, shift 9, 16 sample bits; memories are not cleared.
`default_nettype none
module adaptive_lpc_predictor import alp_pkg::*; #(
  parameter int MAX_ORDER = MaxOrderDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire alp_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output alp_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int HAW = $clog2(MAX_ORDER + 1);
  localparam int CAW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  typedef enum logic [2:0] {S_IDLE, S_DRD, S_DLAT, S_TAP, S_RND} state_t;

  state_t       state_r;
  logic [4:0]   order_r;
  logic [3:0]   q_r;
  logic [5:0]   sbits_r;
  logic [5:0]   wc_r;
  logic [HAW-1:0] wp_r;
  logic [31:0]  res_r, d_r;
  logic [4:0]   j_r, pj_r;
  logic         pv_r;
  logic         out_valid_r;
  alp_out_t     out_data_r;

  logic         in_acc, out_free, warm, issue, rnd_done;
  logic [5:0]   ord6, wc_base;
  logic [4:0]   ord5;
  logic         hist_we;
  logic [HAW-1:0] hist_raddr;
  logic [31:0]  hist_wdata, hist_rd, coef_rd;
  logic         coef_load, coef_we, tap_we;
  logic [CAW-1:0] coef_waddr, coef_raddr;
  logic [31:0]  coef_wdata, tap_wdata, val, rnd, sum, result;
  logic         tap_busy;
  logic [4:0]   sx;
  alp_tap_ctl_t tap_ctl;

  // effective order and warm-up decision
  always_comb begin
    ord6 = ({1'b0, order_r} > 6'(MAX_ORDER)) ? 6'(MAX_ORDER) : {1'b0, order_r};
    ord5 = ord6[4:0];
    wc_base = in_data.frame_start ? 6'd0 : wc_r;
    warm = {1'b0, wc_base} < ({1'b0, ord6} + 7'd1);
    out_free = !out_valid_r || !out_stall;
    in_stall = !((state_r == S_IDLE) && out_free);
    in_acc = in_valid && !in_stall;
    issue = (state_r == S_TAP) && (j_r < ord5);
    rnd_done = (state_r == S_RND) && out_free;
  end

  // rounding, shift, add back and wrap to sample width
  always_comb begin
    rnd = (q_r != 4'd0) ?
          32'($signed(val + (32'd1 << (q_r - 4'd1))) >>> q_r) : val;
    sum = rnd + d_r + res_r;
    sx = 5'(6'd32 - sbits_r);
    if (sbits_r == 6'd0 || sbits_r >= 6'd32) begin
      result = sum;
    end else begin
      result = 32'($signed(sum << sx) >>> sx);
    end
  end

  // history port
  always_comb begin
    hist_we = (in_acc && in_data.mode == MODE_SAMPLE && warm) || rnd_done;
    hist_wdata = (state_r == S_RND) ? result : in_data.residual;
    if (state_r == S_DRD) begin
      hist_raddr = wp_r - HAW'(1) - HAW'(ord6);
    end else begin
      hist_raddr = wp_r - HAW'(ord6) + HAW'(j_r);
    end
  end

  alp_ram #(.Width(32), .Aw(HAW)) u_hist (
    .clk(clk), .we(hist_we), .waddr(wp_r), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rd)
  );

  // coefficient port: loads while idle, adaptation during taps
  always_comb begin
    coef_load = in_acc && (in_data.mode == MODE_LOAD) &&
                ({1'b0, in_data.coef_index} < 6'(MAX_ORDER));
    coef_we = coef_load || tap_we;
    coef_waddr = coef_load ? CAW'(in_data.coef_index) : CAW'(pj_r);
    coef_wdata = coef_load ? in_data.coef_value : tap_wdata;
    coef_raddr = CAW'(j_r);
    tap_ctl.init = (state_r == S_DLAT);
    tap_ctl.p_valid = pv_r;
    tap_ctl.j = pj_r;
    tap_ctl.q = q_r;
  end

  alp_ram #(.Width(32), .Aw(CAW)) u_coef (
    .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(coef_wdata),
    .raddr(coef_raddr), .rdata(coef_rd)
  );

  alp_tap u_tap (
    .clk(clk), .rst_n(rst_n), .ctl(tap_ctl), .res(res_r), .d(d_r),
    .hist_rd(hist_rd), .coef_rd(coef_rd), .coef_we(tap_we),
    .coef_wdata(tap_wdata), .val(val), .busy(tap_busy)
  );

  // sequencer, config and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      order_r <= 5'd0;
      q_r <= 4'd9;
      sbits_r <= 6'd16;
      wc_r <= 6'd0;
      wp_r <= '0;
      pv_r <= 1'b0;
      j_r <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ORDER:  order_r <= cfg_data[4:0];
          REG_QSHIFT: q_r <= cfg_data[3:0];
          REG_SBITS:  sbits_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      pv_r <= issue;
      if (issue) begin
        pj_r <= j_r;
        j_r <= j_r + 5'd1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_data.mode == MODE_SAMPLE) begin
            res_r <= in_data.residual;
            if (warm) begin
              wc_r <= wc_base + 6'd1;
              wp_r <= wp_r + HAW'(1);
              out_valid_r <= 1'b1;
              out_data_r.sample <= in_data.residual;
              out_data_r.warmup <= 1'b1;
            end else begin
              wc_r <= wc_base;
              state_r <= S_DRD;
            end
          end
        end
        S_DRD: state_r <= S_DLAT;
        S_DLAT: begin
          d_r <= hist_rd;
          j_r <= 5'd0;
          state_r <= S_TAP;
        end
        S_TAP: begin
          if (!issue && !pv_r && !tap_busy) begin
            state_r <= S_RND;
          end
        end
        S_RND: begin
          if (out_free) begin
            wp_r <= wp_r + HAW'(1);
            out_valid_r <= 1'b1;
            out_data_r.sample <= result;
            out_data_r.warmup <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // a beat is only loaded into a free result register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_data_r))
    else $error("result overwritten while stalled");

  // every history push comes with a result beat
  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |=> out_valid_r)
    else $error("history push without result");

  // taps only issue below the order
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> ({1'b0, j_r} < ord6))
    else $error("tap issued beyond order");

  // pipeline drained before rounding
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND) |-> (!pv_r && !tap_busy))
    else $error("rounding with taps in flight");

endmodule
`default_nettype wire
